### rtl/two_class_fifo_oldest_first_unit_macros.svh
// ----------------------------------------------------------------------------
// Two-class FIFO assertion macros
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TCFO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TCFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCFO_ASSERT_NOW(label, ante, cons, msg)

`define TCFO_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/tcfo_pkg.sv
// ----------------------------------------------------------------------------
// tcfo_pkg
// Shared sizes, codes and types of the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfo_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 16;
    localparam int STAMP_W     = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_ID_W = 16;
    localparam int IN_ID_W  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ_A   = 3'd0,
        KIND_ENQ_B   = 3'd1,
        KIND_DEQ_ANY = 3'd2,
        KIND_DEQ_A   = 3'd3,
        KIND_DEQ_B   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [ID_WIDTH-1:0] id;
    } entry_t;

endpackage

`default_nettype wire

### rtl/two_class_fifo_oldest_first_unit.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_unit
// Two ring-buffer FIFOs (class A, class B) with arrival stamps and an
// oldest-first dequeue across both classes.
// ----------------------------------------------------------------------------
// Every request yields one response transaction. For enqueues the entry is
// written into its class memory and, as for unused kinds, the response is
// loaded at once. Dequeues pass through S_READ, as the class memories have a
// registered read: the head entries are read on the accept cycle and the
// choice, pop and response happen on the next. A new request is taken in
// S_IDLE when the response register is empty or being drained in that cycle.
`default_nettype none

module two_class_fifo_oldest_first_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tcfo_pkg::IN_ID_W-1:0]   s_tdata,   // item_id
    input  wire logic [tcfo_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tcfo_pkg::OUT_ID_W-1:0]       m_tdata,   // out_id
    output logic [tcfo_pkg::STATUS_W:0]         m_tuser    // status, out_class
);

    import tcfo_pkg::*;

`include "two_class_fifo_oldest_first_unit_macros.svh"

    state_t                state_reg, state_next;
    kind_t                 pend_kind_reg, pend_kind_next;
    logic [PTR_W-1:0]      a_head_reg, a_head_next, b_head_reg, b_head_next;
    logic [CNT_W-1:0]      a_count_reg, a_count_next, b_count_reg, b_count_next;
    logic [STAMP_W-1:0]    arrival_reg, arrival_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    status_t               status_reg, status_next;
    logic [OUT_ID_W-1:0]   oid_reg, oid_next;
    logic                  ocls_reg, ocls_next;

    entry_t                a_mem [QUEUE_DEPTH];
    entry_t                b_mem [QUEUE_DEPTH];
    entry_t                a_rd_reg, b_rd_reg;

    logic                  accept;
    kind_t                 kind;
    logic                  a_full, b_full, a_has, b_has;
    logic [SUM_W-1:0]      a_sum, b_sum;
    logic [PTR_W-1:0]      a_tail, b_tail, a_head_inc, b_head_inc;
    logic                  a_wr, b_wr, enq_ok;
    logic [STAMP_W-1:0]    stamp_diff;
    entry_t                wr_entry;

    assign accept = s_tvalid && s_tready;
    assign kind   = kind_t'(s_tuser);

    assign a_full = (a_count_reg == CNT_W'(QUEUE_DEPTH));
    assign b_full = (b_count_reg == CNT_W'(QUEUE_DEPTH));
    assign a_has  = (a_count_reg != '0);
    assign b_has  = (b_count_reg != '0);

    assign a_sum  = SUM_W'(a_head_reg) + SUM_W'(a_count_reg);
    assign b_sum  = SUM_W'(b_head_reg) + SUM_W'(b_count_reg);
    assign a_tail = (a_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(a_sum - SUM_W'(QUEUE_DEPTH))
                                                   : PTR_W'(a_sum);
    assign b_tail = (b_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(b_sum - SUM_W'(QUEUE_DEPTH))
                                                   : PTR_W'(b_sum);

    assign a_head_inc = (a_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : a_head_reg + PTR_W'(1);
    assign b_head_inc = (b_head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : b_head_reg + PTR_W'(1);

    assign stamp_diff = a_rd_reg.stamp - b_rd_reg.stamp;

    assign wr_entry.stamp = arrival_reg;
    assign wr_entry.id    = ID_WIDTH'(s_tdata);

    assign a_wr   = accept && (kind == KIND_ENQ_A) && !a_full;
    assign b_wr   = accept && (kind == KIND_ENQ_B) && !b_full;
    assign enq_ok = a_wr || b_wr;

    always_comb
    begin
        logic take_a;
        logic take_b;

        take_a         = 1'b0;
        take_b         = 1'b0;
        state_next     = state_reg;
        pend_kind_next = pend_kind_reg;
        a_head_next    = a_head_reg;
        b_head_next    = b_head_reg;
        a_count_next   = a_count_reg;
        b_count_next   = b_count_reg;
        arrival_next   = arrival_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        status_next    = status_reg;
        oid_next       = oid_reg;
        ocls_next      = ocls_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    oid_next  = '0;
                    ocls_next = 1'b0;
                    case (kind)
                        KIND_ENQ_A:
                        begin
                            m_tvalid_next = 1'b1;
                            status_next   = a_full ? ST_FULL : ST_ENQ;
                            if (!a_full)
                            begin
                                a_count_next = a_count_reg + CNT_W'(1);
                                arrival_next = arrival_reg + STAMP_W'(1);
                            end
                        end
                        KIND_ENQ_B:
                        begin
                            m_tvalid_next = 1'b1;
                            status_next   = b_full ? ST_FULL : ST_ENQ;
                            if (!b_full)
                            begin
                                b_count_next = b_count_reg + CNT_W'(1);
                                arrival_next = arrival_reg + STAMP_W'(1);
                            end
                        end
                        KIND_DEQ_ANY, KIND_DEQ_A, KIND_DEQ_B:
                        begin
                            pend_kind_next = kind;
                            state_next     = S_READ;
                        end
                        default:
                        begin
                            m_tvalid_next = 1'b1;
                            status_next   = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (pend_kind_reg)
                    KIND_DEQ_A:   take_a = a_has;
                    KIND_DEQ_B:   take_b = b_has;
                    KIND_DEQ_ANY:
                    begin
                        if (a_has && b_has)
                        begin
                            take_a = stamp_diff[STAMP_W-1];
                            take_b = !stamp_diff[STAMP_W-1];
                        end
                        else
                        begin
                            take_a = a_has;
                            take_b = b_has;
                        end
                    end
                    default: ;
                endcase

                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
                if (take_a)
                begin
                    status_next  = ST_DEQ;
                    oid_next     = OUT_ID_W'(a_rd_reg.id);
                    ocls_next    = 1'b0;
                    a_head_next  = a_head_inc;
                    a_count_next = a_count_reg - CNT_W'(1);
                end
                else if (take_b)
                begin
                    status_next  = ST_DEQ;
                    oid_next     = OUT_ID_W'(b_rd_reg.id);
                    ocls_next    = 1'b1;
                    b_head_next  = b_head_inc;
                    b_count_next = b_count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_EMPTY;
                    oid_next    = '0;
                    ocls_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_kind_reg <= KIND_DEQ_ANY;
            a_head_reg    <= '0;
            b_head_reg    <= '0;
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            arrival_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_kind_reg <= pend_kind_next;
            a_head_reg    <= a_head_next;
            b_head_reg    <= b_head_next;
            a_count_reg   <= a_count_next;
            b_count_reg   <= b_count_next;
            arrival_reg   <= arrival_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        oid_reg    <= oid_next;
        ocls_reg   <= ocls_next;
    end

    // class memories: head read every cycle, tail written on enqueue
    always_ff @(posedge clk)
    begin
        a_rd_reg <= a_mem[a_head_reg];
        if (a_wr)
        begin
            a_mem[a_tail] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        b_rd_reg <= b_mem[b_head_reg];
        if (b_wr)
        begin
            b_mem[b_tail] <= wr_entry;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = oid_reg;
    assign m_tuser  = {ocls_reg, status_reg};

    `TCFO_ASSERT_NOW(a_count_bound, 1'b1, a_count_reg <= CNT_W'(QUEUE_DEPTH),
        "class A occupancy above depth")
    `TCFO_ASSERT_NOW(b_count_bound, 1'b1, b_count_reg <= CNT_W'(QUEUE_DEPTH),
        "class B occupancy above depth")
    `TCFO_ASSERT_NOW(read_out_free, state_reg == S_READ, !m_tvalid_reg,
        "response register busy during head read")
    `TCFO_ASSERT_NEXT(stamp_step, enq_ok, arrival_reg == $past(arrival_reg) + STAMP_W'(1),
        "arrival stamp did not advance on enqueue")

endmodule

`default_nettype wire
